>>> src/fnm_pkg.sv
// shared constants and types of the four-neighbour mean filter
// no dependencies; imported by fnm_front, fnm_back and the top module
`default_nettype none

package fnm_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int FW_W        = 6;
    localparam int FH_W        = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;

    localparam int DEF_MAX_WIDTH  = 32;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam logic [FW_W-1:0] FW_RESET = 6'd10;
    localparam logic [FH_W-1:0] FH_RESET = 11'd10;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    // sum of up to four samples, and exact reciprocal of three for that range
    localparam int SUM_W        = SAMPLE_W + 2;
    localparam int RECIP3_SHIFT = SUM_W + 2;
    localparam int PROD_W       = SUM_W + RECIP3_SHIFT;
    localparam logic [RECIP3_SHIFT-1:0] RECIP3 = 20'd349526;

    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 2;

    typedef struct packed {
        logic emit;     // row above is complete, one mean is due
        logic has_up;   // element being finished has a row above it
        logic row_par;  // parity of the incoming row
        logic last;     // final sample of the frame, last row follows
    } cmd_flags_t;

    typedef struct packed {
        logic                frame_last;
        logic [SAMPLE_W-1:0] mean_value;
    } result_t;

endpackage

`default_nettype wire

>>> src/fnm_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module fnm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> src/fnm_fifo.sv
// small register queue, used between front and back and for results
// no dependencies
`default_nettype none

module fnm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output      logic             full,
    input  wire logic             pop,
    output      logic [WIDTH-1:0] rdata,
    output      logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("queue count missed a push");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (empty || full) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

>>> src/fnm_front.sv
// front part: frame size registers, raster counters and request classification
// depends on fnm_pkg
`default_nettype none

module fnm_front #(
    parameter int MAX_WIDTH  = fnm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = fnm_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output      logic                                cfg_ready,
    input  wire logic [fnm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [fnm_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                push,
    input  wire logic [fnm_pkg::SAMPLE_W-1:0]        sample,
    input  wire logic                                cmd_full,
    output      logic                                cmd_push,
    output      fnm_pkg::cmd_flags_t                 cmd_flags,
    output      logic [$clog2(MAX_WIDTH)-1:0]        cmd_col,
    output      logic [fnm_pkg::SAMPLE_W-1:0]        cmd_sample,
    output      logic [$clog2(MAX_WIDTH + 1)-1:0]    eff_width
);

    import fnm_pkg::*;

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int WIDTH_W  = $clog2(MAX_WIDTH + 1);
    localparam int HEIGHT_W = $clog2(MAX_HEIGHT + 1);

    logic [FW_W-1:0]     fw_reg;
    logic [FH_W-1:0]     fh_reg;
    logic [COL_W-1:0]    col_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [HEIGHT_W-1:0] eff_height;
    logic                last_col;
    logic                last_row;
    logic                accept;

    // frame size clamped to the supported range
    always_comb
    begin
        if (fw_reg < FW_W'(2))
        begin
            eff_width = WIDTH_W'(2);
        end
        else if (32'(fw_reg) > 32'(MAX_WIDTH))
        begin
            eff_width = WIDTH_W'(MAX_WIDTH);
        end
        else
        begin
            eff_width = WIDTH_W'(fw_reg);
        end

        if (fh_reg < FH_W'(2))
        begin
            eff_height = HEIGHT_W'(2);
        end
        else if (32'(fh_reg) > 32'(MAX_HEIGHT))
        begin
            eff_height = HEIGHT_W'(MAX_HEIGHT);
        end
        else
        begin
            eff_height = HEIGHT_W'(fh_reg);
        end
    end

    assign last_col = (32'(col_reg) + 32'd1 == 32'(eff_width));
    assign last_row = (32'(row_reg) + 32'd1 == 32'(eff_height));
    assign accept   = push && !cmd_full;

    assign cfg_ready         = 1'b1;
    assign cmd_push          = accept;
    assign cmd_col           = col_reg;
    assign cmd_sample        = sample;
    assign cmd_flags.emit    = (row_reg != '0);
    assign cmd_flags.has_up  = (32'(row_reg) >= 32'd2);
    assign cmd_flags.row_par = row_reg[0];
    assign cmd_flags.last    = last_row && last_col;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg  <= FW_RESET;
            fh_reg  <= FH_RESET;
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:
                begin
                    fw_reg  <= cfg_data[FW_W-1:0];
                    col_reg <= '0;
                    row_reg <= '0;
                end
                REG_FRAME_HEIGHT:
                begin
                    fh_reg  <= cfg_data[FH_W-1:0];
                    col_reg <= '0;
                    row_reg <= '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_reg) < 32'(eff_width))
        else $error("column counter outside frame");

    a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        32'(row_reg) < 32'(eff_height))
        else $error("row counter outside frame");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd_flags.last) |=> (col_reg == '0 && row_reg == '0))
        else $error("counters did not wrap at end of frame");

endmodule

`default_nettype wire

>>> src/fnm_back.sv
// back part: row buffers, neighbour gather, divide by count, result hand-off
// depends on fnm_pkg and fnm_ram
`default_nettype none

module fnm_back #(
    parameter int MAX_WIDTH = fnm_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [$clog2(MAX_WIDTH + 1)-1:0] eff_width,
    input  wire logic                             cmd_empty,
    output      logic                             cmd_pop,
    input  wire fnm_pkg::cmd_flags_t              cmd_flags,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]     cmd_col,
    input  wire logic [fnm_pkg::SAMPLE_W-1:0]     cmd_sample,
    input  wire logic                             res_full,
    output      logic                             res_push,
    output      fnm_pkg::result_t                 res_data
);

    import fnm_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int DEPTH  = 2 * MAX_WIDTH;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP,
        ST_LEFT,
        ST_RIGHT,
        ST_GATHER,
        ST_DIV,
        ST_PUSH
    } state_t;

    state_t               state_reg;
    logic                 flush_reg;
    logic                 row_par_reg;
    logic                 has_up_reg;
    logic                 last_reg;
    logic [COL_W-1:0]     col_reg;
    logic [SAMPLE_W-1:0]  down_reg;
    logic [SAMPLE_W-1:0]  up_val_reg;
    logic [SAMPLE_W-1:0]  left_val_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [2:0]           cnt_reg;
    logic [PROD_W-1:0]    prod_reg;

    logic                 elem_par;
    logic                 has_up;
    logic                 has_left;
    logic                 has_right;
    logic [SUM_W-1:0]     sum_next;
    logic [2:0]           cnt_next;
    logic [SAMPLE_W-1:0]  mean;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [SAMPLE_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [SAMPLE_W-1:0]  ram_rdata;

    function automatic logic [ADDR_W-1:0] slot_addr(input logic par,
                                                    input logic [COL_W-1:0] col);
        slot_addr = par ? ADDR_W'(MAX_WIDTH) + ADDR_W'(col) : ADDR_W'(col);
    endfunction

    // normal requests finish the row above; the flush finishes the incoming row
    assign elem_par  = flush_reg ? row_par_reg : !row_par_reg;
    assign has_up    = flush_reg || has_up_reg;
    assign has_left  = (col_reg != '0);
    assign has_right = (32'(col_reg) + 32'd1 < 32'(eff_width));

    assign cmd_pop  = (state_reg == ST_IDLE) && !cmd_empty;
    assign res_push = (state_reg == ST_PUSH) && !res_full;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = slot_addr(row_par_reg, col_reg);
        ram_wdata = down_reg;
        if (cmd_pop && !cmd_flags.emit)
        begin
            ram_we    = 1'b1;
            ram_waddr = slot_addr(cmd_flags.row_par, cmd_col);
            ram_wdata = cmd_sample;
        end
        else if (state_reg == ST_GATHER && !flush_reg)
        begin
            ram_we = 1'b1;
        end
    end

    always_comb
    begin
        unique case (state_reg)
            ST_LEFT:  ram_raddr = slot_addr(elem_par,
                                            has_left ? col_reg - COL_W'(1) : col_reg);
            ST_RIGHT: ram_raddr = slot_addr(elem_par,
                                            has_right ? col_reg + COL_W'(1) : col_reg);
            default:  ram_raddr = slot_addr(!elem_par, col_reg);
        endcase
    end

    always_comb
    begin
        sum_next = SUM_W'(has_up ? up_val_reg : '0)
                 + SUM_W'(has_left ? left_val_reg : '0)
                 + SUM_W'(has_right ? ram_rdata : '0)
                 + SUM_W'(flush_reg ? '0 : down_reg);
        cnt_next = 3'(has_up) + 3'(has_left) + 3'(has_right) + 3'(!flush_reg);
    end

    always_comb
    begin
        case (cnt_reg)
            3'd2:    mean = sum_reg[SAMPLE_W:1];
            3'd3:    mean = prod_reg[RECIP3_SHIFT +: SAMPLE_W];
            default: mean = sum_reg[SAMPLE_W+1:2];
        endcase
    end

    assign res_data.mean_value = mean;
    assign res_data.frame_last = flush_reg && !has_right;

    fnm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_row_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // data path, no reset needed
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LEFT)
        begin
            up_val_reg <= ram_rdata;
        end
        if (state_reg == ST_RIGHT)
        begin
            left_val_reg <= ram_rdata;
        end
        if (state_reg == ST_GATHER)
        begin
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
        end
        if (state_reg == ST_DIV)
        begin
            prod_reg <= PROD_W'(sum_reg) * PROD_W'(RECIP3);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            flush_reg   <= 1'b0;
            row_par_reg <= 1'b0;
            has_up_reg  <= 1'b0;
            last_reg    <= 1'b0;
            col_reg     <= '0;
            down_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_pop)
                    begin
                        flush_reg   <= 1'b0;
                        row_par_reg <= cmd_flags.row_par;
                        has_up_reg  <= cmd_flags.has_up;
                        last_reg    <= cmd_flags.last;
                        col_reg     <= cmd_col;
                        down_reg    <= cmd_sample;
                        if (cmd_flags.emit)
                        begin
                            state_reg <= ST_UP;
                        end
                    end
                end
                ST_UP:     state_reg <= ST_LEFT;
                ST_LEFT:   state_reg <= ST_RIGHT;
                ST_RIGHT:  state_reg <= ST_GATHER;
                ST_GATHER: state_reg <= ST_DIV;
                ST_DIV:    state_reg <= ST_PUSH;
                ST_PUSH:
                begin
                    if (!res_full)
                    begin
                        if (!flush_reg && last_reg)
                        begin
                            // whole last row follows, left to right
                            flush_reg <= 1'b1;
                            col_reg   <= '0;
                            state_reg <= ST_UP;
                        end
                        else if (flush_reg && has_right)
                        begin
                            col_reg   <= col_reg + COL_W'(1);
                            state_reg <= ST_UP;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_no_write_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && flush_reg && state_reg != ST_IDLE))
        else $error("row buffer written during flush");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUSH) |-> (cnt_reg == 3'd2 || cnt_reg == 3'd3 || cnt_reg == 3'd4))
        else $error("neighbour count out of range");

    a_flush_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(flush_reg) |-> $past(last_reg))
        else $error("flush started without final sample");

    a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res_data.frame_last) |=> state_reg == ST_IDLE)
        else $error("work continued after final result");

endmodule

`default_nettype wire

>>> src/four_neighbor_mean_filter.sv
// four-neighbour mean filter: replaces each element of a raster frame by the
// truncated mean of its up, down, left and right neighbours inside the frame.
// channels: sample in by push/full, results out by empty/pop, and a config write
// channel (cfg_valid/cfg_ready, cfg_index, cfg_data) for frame width (0) and
// height (1); a write to either restarts the frame, other indexes are ignored.
// samples of the first row are only stored; every later sample finishes the
// element above it, and the last sample of the frame also finishes the whole
// last row, whose final result carries frame_last.
// each later sample passes the back unit in order: take the request, three reads
// through the single read port of the row buffer, sum, multiply by the reciprocal
// of three, hand-off; a flushed column skips the first step. the back unit takes
// no new request until it has handed off its result; first-row samples are taken
// one per cycle while the back unit is idle, and the end of frame flush visits
// every column of the last row after the final sample.
// reset: counters at row 0 column 0, frame 10 by 10, both queues empty.
// when the receiver stops popping, the two-entry result queue fills, the back
// unit holds its result, the two-entry request queue fills and full rises.
// depends on fnm_pkg, fnm_front, fnm_back, fnm_fifo, fnm_ram
`default_nettype none

module four_neighbor_mean_filter #(
    parameter int MAX_WIDTH  = fnm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = fnm_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output      logic                            cfg_ready,
    input  wire logic [fnm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [fnm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            push,
    output      logic                            full,
    input  wire logic [fnm_pkg::SAMPLE_W-1:0]    sample,
    output      logic                            empty,
    input  wire logic                            pop,
    output      logic [fnm_pkg::SAMPLE_W-1:0]    mean_value,
    output      logic                            frame_last
);

    import fnm_pkg::*;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int WIDTH_W = $clog2(MAX_WIDTH + 1);
    localparam int CMD_W   = $bits(cmd_flags_t) + COL_W + SAMPLE_W;
    localparam int RES_W   = $bits(result_t);

    logic                cmd_push;
    logic                cmd_full;
    logic                cmd_pop;
    logic                cmd_empty;
    cmd_flags_t          fr_flags;
    logic [COL_W-1:0]    fr_col;
    logic [SAMPLE_W-1:0] fr_sample;
    logic [CMD_W-1:0]    cmd_wdata;
    logic [CMD_W-1:0]    cmd_rdata;
    cmd_flags_t          bk_flags;
    logic [COL_W-1:0]    bk_col;
    logic [SAMPLE_W-1:0] bk_sample;
    logic [WIDTH_W-1:0]  eff_width;
    logic                res_push;
    logic                res_full;
    result_t             res_in;
    result_t             res_out;

    assign full      = cmd_full;
    assign cmd_wdata = {fr_flags, fr_col, fr_sample};
    assign {bk_flags, bk_col, bk_sample} = cmd_rdata;

    fnm_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .sample     (sample),
        .cmd_full   (cmd_full),
        .cmd_push   (cmd_push),
        .cmd_flags  (fr_flags),
        .cmd_col    (fr_col),
        .cmd_sample (fr_sample),
        .eff_width  (eff_width)
    );

    fnm_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_wdata),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (cmd_rdata),
        .empty (cmd_empty)
    );

    fnm_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .eff_width  (eff_width),
        .cmd_empty  (cmd_empty),
        .cmd_pop    (cmd_pop),
        .cmd_flags  (bk_flags),
        .cmd_col    (bk_col),
        .cmd_sample (bk_sample),
        .res_full   (res_full),
        .res_push   (res_push),
        .res_data   (res_in)
    );

    fnm_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_out),
        .empty (empty)
    );

    assign mean_value = res_out.mean_value;
    assign frame_last = res_out.frame_last;

endmodule

`default_nettype wire
